### rtl/pnhc_pkg.sv
// Shared types, constants and hash step functions of the nonce hash checker.
package pnhc_pkg;

  // Message layout
  localparam int CHAL_WORDS  = 4;
  localparam int CHAL_BYTES  = 32;
  localparam int NONCE_BYTES = 8;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CHALLENGE_0    = 3'd0,
    CFG_CHALLENGE_1    = 3'd1,
    CFG_CHALLENGE_2    = 3'd2,
    CFG_CHALLENGE_3    = 3'd3,
    CFG_REQUIRED_ZEROS = 3'd4
  } cfg_index_t;

  localparam logic [8:0] REQ_ZEROS_RESET = 9'd20;

  // Lane constants; lane A multiplier 2^40 + 0x1b3 is applied as shifts
  localparam logic [63:0] LANE_A_INIT    = 64'hcbf29ce484222325;
  localparam logic [63:0] LANE_B_INIT    = 64'h00000100000001b3;
  localparam logic [63:0] LANE_B_MUL     = 64'hcbf29ce484222325;
  localparam logic [31:0] LANE_B_MUL_LO  = LANE_B_MUL[31:0];
  localparam logic [31:0] LANE_B_MUL_HI  = LANE_B_MUL[63:32];

  // Input word
  typedef struct packed {
    logic        kind;
    logic [63:0] nonce;
    logic [63:0] claimed_hash_0;
    logic [63:0] claimed_hash_1;
    logic [63:0] claimed_hash_2;
    logic [63:0] claimed_hash_3;
    logic [63:0] claimed_challenge_0;
    logic [63:0] claimed_challenge_1;
    logic [63:0] claimed_challenge_2;
    logic [63:0] claimed_challenge_3;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [63:0] digest_0;
    logic [63:0] digest_1;
    logic [63:0] digest_2;
    logic [63:0] digest_3;
    logic [8:0]  zero_bits;
    logic        meets_difficulty;
    logic        solution_valid;
  } out_word_t;

  // Both lane states
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
  } lane_t;

  // Lane A already stepped, lane B held as partial products
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] lo;
    logic [31:0] c1;
    logic [31:0] c2;
  } mul_t;

  // Per-word context carried alongside the lanes
  typedef struct packed {
    logic                  kind;
    logic                  ch_ok;
    logic [63:0]           nonce;
    logic [3:0][63:0]      claimed_hash;
  } ctx_t;

  // Hash pipeline result handed to the scoring stages
  typedef struct packed {
    lane_t lanes;
    ctx_t  ctx;
  } hp_t;

  // Lane A: xor byte, multiply by 2^40 + 0x1b3
  function automatic logic [63:0] lane_a_step(input logic [63:0] a, input logic [7:0] by);
    logic [63:0] x;
    x = a ^ {56'd0, by};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  // First half of a byte step: lane A complete, lane B partial products
  function automatic mul_t lane_mul(input lane_t l, input logic [7:0] by);
    mul_t        m;
    logic [63:0] x;
    x    = l.b ^ {56'd0, by};
    m.a  = lane_a_step(l.a, by);
    m.lo = x[31:0] * LANE_B_MUL_LO;
    m.c1 = x[63:32] * LANE_B_MUL_LO;
    m.c2 = x[31:0] * LANE_B_MUL_HI;
    return m;
  endfunction

  // Second half of a byte step: gather lane B partial products mod 2^64
  function automatic lane_t lane_sum(input mul_t m);
    lane_t l;
    l.a = m.a;
    l.b = m.lo + {m.c1 + m.c2, 32'd0};
    return l;
  endfunction

  // Leading zeros of a byte, MSB first; 8 for zero
  function automatic logic [3:0] clz_byte(input logic [7:0] b);
    logic [3:0] z;
    logic       hit;
    z   = 4'd0;
    hit = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!hit) begin
        if (b[i]) hit = 1'b1;
        else      z = z + 4'd1;
      end
    end
    return z;
  endfunction

  // Leading zeros of a digest word, low byte first; 64 for zero
  function automatic logic [6:0] clz_word(input logic [63:0] w);
    logic [6:0] z;
    logic       hit;
    z   = 7'd0;
    hit = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!hit) begin
        if (w[8*k +: 8] == 8'd0) begin
          z = z + 7'd8;
        end else begin
          z   = z + {3'd0, clz_byte(w[8*k +: 8])};
          hit = 1'b1;
        end
      end
    end
    return z;
  endfunction

endpackage

### rtl/pnhc_if.sv
// Valid/ready stream interfaces for the input and result words.
interface pnhc_in_if ();
  logic               valid;
  logic               ready;
  pnhc_pkg::in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pnhc_out_if ();
  logic                valid;
  logic                ready;
  pnhc_pkg::out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/pnhc_prefix.sv
// Sequential hash of the 32 challenge bytes into the lane state the nonce starts from.
module pnhc_prefix (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  restart,
  input  logic [3:0][63:0]      challenge,
  output pnhc_pkg::lane_t       lanes,
  output logic                  busy
);

  localparam int CNT_W = $clog2(pnhc_pkg::CHAL_BYTES + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             phase_r;
  pnhc_pkg::lane_t  lane_r;
  pnhc_pkg::mul_t   mul_r;
  pnhc_pkg::mul_t   mul_nxt;
  logic [7:0]       byte_sel;

  assign busy  = (cnt_r != CNT_W'(pnhc_pkg::CHAL_BYTES));
  assign lanes = lane_r;

  // Pick challenge byte: word from the upper count bits, byte from the lower
  assign byte_sel = challenge[cnt_r[4:3]][{cnt_r[2:0], 3'b000} +: 8];
  assign mul_nxt  = pnhc_pkg::lane_mul(lane_r, byte_sel);

  // Each byte in two halves: partial products, then gather
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      cnt_r    <= '0;
      phase_r  <= 1'b0;
      lane_r.a <= pnhc_pkg::LANE_A_INIT;
      lane_r.b <= pnhc_pkg::LANE_B_INIT;
    end else if (busy) begin
      if (!phase_r) begin
        phase_r <= 1'b1;
      end else begin
        lane_r  <= pnhc_pkg::lane_sum(mul_r);
        cnt_r   <= cnt_r + CNT_W'(1);
        phase_r <= 1'b0;
      end
    end
  end

  // Hold partial products between the two halves
  always_ff @(posedge clk) begin
    if (busy && !phase_r) begin
      mul_r <= mul_nxt;
    end
  end

endmodule

### rtl/pnhc_hash_pipe.sv
// Eight nonce byte steps of both lanes, two pipeline stages per byte.
module pnhc_hash_pipe (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  pnhc_pkg::in_word_t   up_word,
  input  logic [3:0][63:0]     challenge,
  input  pnhc_pkg::lane_t      prefix,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output pnhc_pkg::hp_t        dn_word
);

  localparam int BYTES  = pnhc_pkg::NONCE_BYTES;
  localparam int STAGES = 2 * BYTES;

  logic            v_r   [STAGES];
  logic            en    [STAGES];
  pnhc_pkg::ctx_t  ctx_r [STAGES];
  pnhc_pkg::mul_t  mul_r [BYTES];
  pnhc_pkg::lane_t lane_r[BYTES];
  pnhc_pkg::ctx_t  ctx_in;

  // Stage advances when empty or when the next one takes its word
  always_comb begin
    en[STAGES-1] = !v_r[STAGES-1] || dn_ready;
    for (int s = STAGES - 2; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[STAGES-1];
  assign dn_word  = '{lanes: lane_r[BYTES-1], ctx: ctx_r[STAGES-1]};

  // Build the carried context; check the claimed challenge on entry
  always_comb begin
    ctx_in.kind         = up_word.kind;
    ctx_in.nonce        = up_word.nonce;
    ctx_in.claimed_hash = {up_word.claimed_hash_3, up_word.claimed_hash_2,
                           up_word.claimed_hash_1, up_word.claimed_hash_0};
    ctx_in.ch_ok        = (up_word.claimed_challenge_0 == challenge[0]) &&
                          (up_word.claimed_challenge_1 == challenge[1]) &&
                          (up_word.claimed_challenge_2 == challenge[2]) &&
                          (up_word.claimed_challenge_3 == challenge[3]);
  end

  for (genvar j = 0; j < BYTES; j++) begin : g_byte
    pnhc_pkg::lane_t src_lane;
    pnhc_pkg::ctx_t  src_ctx;
    logic            src_v;
    pnhc_pkg::mul_t  mul_nxt;
    pnhc_pkg::lane_t lane_nxt;

    if (j == 0) begin : g_head
      assign src_lane = prefix;
      assign src_ctx  = ctx_in;
      assign src_v    = up_valid;
    end else begin : g_body
      assign src_lane = lane_r[j-1];
      assign src_ctx  = ctx_r[2*j-1];
      assign src_v    = v_r[2*j-1];
    end

    assign mul_nxt  = pnhc_pkg::lane_mul(src_lane, src_ctx.nonce[8*j +: 8]);
    assign lane_nxt = pnhc_pkg::lane_sum(mul_r[j]);

    // Advance valid bits of both halves
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[2*j]   <= 1'b0;
        v_r[2*j+1] <= 1'b0;
      end else begin
        if (en[2*j])   v_r[2*j]   <= src_v;
        if (en[2*j+1]) v_r[2*j+1] <= v_r[2*j];
      end
    end

    // Multiply half, then gather half
    always_ff @(posedge clk) begin
      if (en[2*j]) begin
        mul_r[j]   <= mul_nxt;
        ctx_r[2*j] <= src_ctx;
      end
      if (en[2*j+1]) begin
        lane_r[j]    <= lane_nxt;
        ctx_r[2*j+1] <= ctx_r[2*j];
      end
    end
  end

endmodule

### rtl/pnhc_score.sv
// Digest fold, leading zero count, difficulty and solution checks over three stages.
module pnhc_score (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  pnhc_pkg::hp_t        up_word,
  input  logic [8:0]           req_zeros,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output pnhc_pkg::out_word_t  dn_word
);

  logic             v1_r, v2_r, v3_r;
  logic             en1, en2, en3;
  logic [3:0][63:0] dig1_r, dig1_nxt;
  logic             chk1_r, chk1_nxt;
  logic [3:0][63:0] dig2_r;
  logic [3:0][6:0]  zw2_r, zw2_nxt;
  logic             chk2_r;
  pnhc_pkg::out_word_t out_r, out_nxt;
  logic [8:0]       zb;
  logic             meets;

  // Stage enables, last stage is the output register
  assign en3      = !v3_r || dn_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;
  assign dn_valid = v3_r;
  assign dn_word  = out_r;

  // Fold lanes into the digest; check kind, challenge and claimed hash
  always_comb begin
    dig1_nxt[0] = up_word.lanes.a;
    dig1_nxt[1] = up_word.lanes.b;
    dig1_nxt[2] = up_word.lanes.a ^ up_word.lanes.b;
    dig1_nxt[3] = up_word.lanes.b ^ {32'd0, dig1_nxt[2][63:32]};
    chk1_nxt    = up_word.ctx.kind && up_word.ctx.ch_ok &&
                  (dig1_nxt == up_word.ctx.claimed_hash);
  end

  // Count leading zeros per digest word
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      zw2_nxt[k] = pnhc_pkg::clz_word(dig1_r[k]);
    end
  end

  // Join word counts: a full word of zeros shows as bit 6 set
  always_comb begin
    if (!zw2_r[0][6])      zb = {2'd0, zw2_r[0]};
    else if (!zw2_r[1][6]) zb = 9'd64 + {2'd0, zw2_r[1]};
    else if (!zw2_r[2][6]) zb = 9'd128 + {2'd0, zw2_r[2]};
    else                   zb = 9'd192 + {2'd0, zw2_r[3]};
    meets = (zb >= req_zeros);
    out_nxt.digest_0         = dig2_r[0];
    out_nxt.digest_1         = dig2_r[1];
    out_nxt.digest_2         = dig2_r[2];
    out_nxt.digest_3         = dig2_r[3];
    out_nxt.zero_bits        = zb;
    out_nxt.meets_difficulty = meets;
    out_nxt.solution_valid   = meets && chk2_r;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en1) begin
      dig1_r <= dig1_nxt;
      chk1_r <= chk1_nxt;
    end
    if (en2) begin
      dig2_r <= dig1_r;
      zw2_r  <= zw2_nxt;
      chk2_r <= chk1_r;
    end
    if (en3) begin
      out_r <= out_nxt;
    end
  end

endmodule

### rtl/pow_nonce_hash_check.sv
// Top level of the proof-of-work nonce hash checker.
//
//  channel   direction  handshake           word
//  in_word   sink       valid / ready       kind, nonce, claimed hash and challenge
//  out_word  source     valid / ready       digest, zero_bits, meets, solution_valid
//  cfg_*     write      cfg_we, no ready    challenge words, required_zeros
//
// One word per cycle sustained while the output takes words and no rehash runs; each
// word passes two stages per nonce byte (the lane B 64-bit multiply split into 32-bit
// partial products) plus three scoring stages.
// After reset and after every configuration write the challenge prefix is rehashed
// by a shared unit, a byte at a time in two halves; in_word.ready stays low meanwhile.
// Each stage has its own handshake: a stalled output holds, bubbles behind it close.
module pow_nonce_hash_check (
  input  logic                              clk,
  input  logic                              rst_n,
  pnhc_in_if.sink                           in_word,
  pnhc_out_if.source                        out_word,
  input  logic                              cfg_we,
  input  logic [pnhc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pnhc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [3:0][63:0] chal_r;
  logic [8:0]       req_r;
  pnhc_pkg::lane_t  prefix;
  logic             pre_busy;
  logic             hp_up_valid, hp_up_ready;
  logic             hp_dn_valid, hp_dn_ready;
  pnhc_pkg::hp_t    hp_dn_word;
  logic             gate;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chal_r <= '0;
      req_r  <= pnhc_pkg::REQ_ZEROS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pnhc_pkg::CFG_CHALLENGE_0:    chal_r[0] <= cfg_wdata;
        pnhc_pkg::CFG_CHALLENGE_1:    chal_r[1] <= cfg_wdata;
        pnhc_pkg::CFG_CHALLENGE_2:    chal_r[2] <= cfg_wdata;
        pnhc_pkg::CFG_CHALLENGE_3:    chal_r[3] <= cfg_wdata;
        pnhc_pkg::CFG_REQUIRED_ZEROS: req_r     <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // Hold input while the prefix is rehashed or a write lands
  assign gate             = !pre_busy && !cfg_we;
  assign hp_up_valid      = in_word.valid && gate;
  assign in_word.ready    = hp_up_ready && gate;

  pnhc_prefix u_prefix (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (cfg_we),
    .challenge (chal_r),
    .lanes     (prefix),
    .busy      (pre_busy)
  );

  pnhc_hash_pipe u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (hp_up_valid),
    .up_ready  (hp_up_ready),
    .up_word   (in_word.payload),
    .challenge (chal_r),
    .prefix    (prefix),
    .dn_valid  (hp_dn_valid),
    .dn_ready  (hp_dn_ready),
    .dn_word   (hp_dn_word)
  );

  pnhc_score u_score (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (hp_dn_valid),
    .up_ready  (hp_dn_ready),
    .up_word   (hp_dn_word),
    .req_zeros (req_r),
    .dn_valid  (out_word.valid),
    .dn_ready  (out_word.ready),
    .dn_word   (out_word.payload)
  );

endmodule
